### rtl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants for the version tag parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

    localparam int TAG_LENGTH = 16;
    localparam int POS_W      = 5;
    localparam int MARK_W     = $clog2(TAG_LENGTH);

    localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
    localparam logic [7:0]       CH_V        = 8'h56;
    localparam logic [7:0]       CH_DOT      = 8'h2E;
    localparam logic [7:0]       CH_ZERO     = 8'h30;
    localparam logic [7:0]       CH_NINE     = 8'h39;
    localparam logic [15:0]      BAD_VERSION = 16'hFFFF;
    localparam logic [7:0]       ACC_LIMIT   = 8'd10;

    typedef enum logic [1:0] {
        PH_MAJOR = 2'd0,
        PH_MINOR = 2'd1,
        PH_DOT2  = 2'd2,
        PH_PATCH = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [POS_W-1:0]    position;
        logic [MARK_W-1:0]   marker_pos;
        logic [7:0]          major_acc;
        logic [7:0]          minor_acc;
        logic [7:0]          patch_acc;
        logic                run_stopped;
        logic                dot_pending;
        logic                error_flag;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:       PH_MAJOR,
        position:    '0,
        marker_pos:  '0,
        major_acc:   '0,
        minor_acc:   '0,
        patch_acc:   '0,
        run_stopped: 1'b0,
        dot_pending: 1'b0,
        error_flag:  1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [11:0] times_ten_plus(input logic [7:0] acc,
                                                   input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return ({1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}) + {4'b0000, d};
    endfunction

    function automatic logic [7:0] sat_acc(input logic [7:0] acc, input logic [7:0] c);
        logic [11:0] v;
        v = times_ten_plus(acc, c);
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage

`default_nettype wire

### rtl/version_tag_parser.sv
// ----------------------------------------------------------------------------
// version_tag_parser
// Parses a file-name version tag and reports major*256 + minor*10 + patch.
// ----------------------------------------------------------------------------
// The block takes one tag byte per cycle while s_axis_tready is high and
// computes its next parse state in the same cycle; the result is valid in the
// cycle after the final byte. The result sits in an output register;
// a new byte is taken whenever that register is empty or is being drained.
`default_nettype none

module version_tag_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] version
    output logic [0:0]       m_axis_tuser    // [0] valid_res
);

    vtp_pkg::t_state r_state;
    vtp_pkg::t_state n_state;
    logic [15:0]     n_version;
    logic            n_ok;
    logic            r_out_valid;
    logic [15:0]     r_version;
    logic            r_ok;
    logic            accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    vtp_step u_step (
        .i_state   (r_state),
        .i_char    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_state   (n_state),
        .o_version (n_version),
        .o_ok      (n_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vtp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept && s_axis_tlast) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tlast) begin
            r_version <= n_version;
            r_ok      <= n_ok;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_version;
    assign m_axis_tuser[0] = r_ok;

endmodule

`default_nettype wire

### rtl/vtp_step.sv
// ----------------------------------------------------------------------------
// vtp_step
// Next-state and result logic for one tag byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_step (
    input  var vtp_pkg::t_state i_state,
    input  wire logic [7:0]     i_char,
    input  wire logic           i_last,
    output vtp_pkg::t_state     o_state,
    output logic [15:0]         o_version,
    output logic                o_ok
);

    vtp_pkg::t_state s;
    logic [vtp_pkg::POS_W-1:0] mark_ext;
    logic [vtp_pkg::POS_W-1:0] mark_dist;
    logic                      digit;
    logic [7:0]                minor_x10;

    always_comb begin
        s         = i_state;
        digit     = vtp_pkg::is_digit(i_char);
        mark_ext  = vtp_pkg::POS_W'(i_state.marker_pos);
        mark_dist = i_state.position - mark_ext;

        if (i_state.position >= vtp_pkg::POS_W'(vtp_pkg::TAG_LENGTH)) begin
            s.error_flag = 1'b1;
        end

        if (!s.error_flag) begin
            unique case (i_state.phase)
                vtp_pkg::PH_MAJOR: begin
                    if (i_char == vtp_pkg::CH_V) begin
                        s.marker_pos  = i_state.position[vtp_pkg::MARK_W-1:0];
                        s.major_acc   = '0;
                        s.run_stopped = 1'b0;
                    end else if (i_char == vtp_pkg::CH_DOT) begin
                        if (i_state.marker_pos == '0 || mark_dist < vtp_pkg::POS_W'(2)) begin
                            s.error_flag = 1'b1;
                        end else begin
                            s.phase       = vtp_pkg::PH_MINOR;
                            s.marker_pos  = i_state.position[vtp_pkg::MARK_W-1:0];
                            s.run_stopped = 1'b0;
                        end
                    end else if (!i_state.run_stopped && digit) begin
                        s.major_acc = 8'(vtp_pkg::times_ten_plus(i_state.major_acc, i_char));
                    end else begin
                        s.run_stopped = 1'b1;
                    end
                end
                vtp_pkg::PH_MINOR: begin
                    if (i_char == vtp_pkg::CH_DOT) begin
                        if (mark_dist == vtp_pkg::POS_W'(1) ||
                            i_state.minor_acc >= vtp_pkg::ACC_LIMIT) begin
                            s.error_flag = 1'b1;
                        end else begin
                            s.phase       = vtp_pkg::PH_DOT2;
                            s.marker_pos  = i_state.position[vtp_pkg::MARK_W-1:0];
                            s.run_stopped = 1'b0;
                            if (i_last) begin
                                s.error_flag = 1'b1;
                            end
                        end
                    end else if (!i_state.run_stopped && digit) begin
                        s.minor_acc = vtp_pkg::sat_acc(i_state.minor_acc, i_char);
                    end else begin
                        s.run_stopped = 1'b1;
                    end
                end
                vtp_pkg::PH_DOT2, vtp_pkg::PH_PATCH: begin
                    s.phase = vtp_pkg::PH_PATCH;
                    if (!i_state.run_stopped) begin
                        if (i_char == vtp_pkg::CH_DOT) begin
                            if (i_state.dot_pending) begin
                                s.run_stopped = 1'b1;
                            end else begin
                                s.dot_pending = 1'b1;
                            end
                        end else if (digit) begin
                            s.dot_pending = 1'b0;
                            s.patch_acc   = vtp_pkg::sat_acc(i_state.patch_acc, i_char);
                        end else begin
                            s.run_stopped = 1'b1;
                        end
                    end
                end
                default: begin
                    s.error_flag = 1'b1;
                end
            endcase
        end

        if (i_state.position < vtp_pkg::POS_MAX) begin
            s.position = i_state.position + vtp_pkg::POS_W'(1);
        end

        o_ok = !s.error_flag && (s.phase == vtp_pkg::PH_PATCH) &&
               (s.patch_acc < vtp_pkg::ACC_LIMIT);
        minor_x10 = {s.minor_acc[4:0], 3'b000} + {s.minor_acc[6:0], 1'b0};
        if (o_ok) begin
            o_version = {s.major_acc, 8'h00} + {8'h00, minor_x10} + {8'h00, s.patch_acc};
        end else begin
            o_version = vtp_pkg::BAD_VERSION;
        end

        o_state = i_last ? vtp_pkg::STATE_RESET : s;
    end

endmodule

`default_nettype wire
